// ===== sv/rpm_pkg.sv =====
// rpm_pkg: shared constants and the command/status structs of the run level meter.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package rpm_pkg;

   localparam int CHANS       = 4;
   localparam int CHAN_BITS   = 2;
   localparam int RUN_ID_BITS = 4;
   localparam int SUM_BITS    = 64;
   localparam int COUNT_BITS  = 32;
   localparam int ROOT_BITS   = 32;

   localparam logic                 MODE_SAMPLE = 1'b0;
   localparam logic                 MODE_REPORT = 1'b1;
   localparam logic [CHAN_BITS-1:0] CHAN_LAST   = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic clear;       // write zeros at the sweep pointer, advance it
      logic load;        // capture the request transaction
      logic square;      // register absolute values and squares
      logic write;       // write back the updated run entry
      logic div_start;   // start sum / count for the current channel
      logic sqrt_start;  // start the root of the quotient
      logic out_load;    // load the result register
      logic next_chan;   // advance to the next channel of a report
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic is_report;
      logic div_busy;
      logic sqrt_busy;
      logic chan_last;
   } sts_type;

endpackage

// ===== sv/rpm_ram.sv =====
// rpm_ram: generic single-write, single-read memory with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rpm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/rpm_ctrl.sv =====
// rpm_ctrl: sequencer of the run level meter (clear sweep, sample update, report).
// Depends on rpm_pkg for the command and status structs.
`timescale 1ns / 1ps

module rpm_ctrl
   import rpm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_WRITE = 3'd3;
   localparam logic [2:0] ST_CHAN  = 3'd4;
   localparam logic [2:0] ST_DIV   = 3'd5;
   localparam logic [2:0] ST_SQRT  = 3'd6;
   localparam logic [2:0] ST_OUT   = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.square = 1'b1;
            state_in   = sts.is_report ? ST_CHAN : ST_WRITE;
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_CHAN: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (!sts.div_busy) begin
               cmd.sqrt_start = 1'b1;
               state_in       = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (!sts.sqrt_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               if (sts.chan_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.next_chan = 1'b1;
                  state_in      = ST_CHAN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/rpm_dp.sv =====
// rpm_dp: datapath of the run level meter: run stores, square/accumulate lanes,
// shared bit-serial divider and square root, result register. Uses rpm_pkg, rpm_ram.
`timescale 1ns / 1ps

module rpm_dp
   import rpm_pkg::*;
#(
   parameter int RUNS        = 16,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cmd_type                       cmd,
   output sts_type                       sts,
   input  logic                          req_mode,
   input  logic [RUN_ID_BITS-1:0]        req_run_id,
   input  logic signed [SAMPLE_BITS-1:0] req_in_left,
   input  logic signed [SAMPLE_BITS-1:0] req_in_right,
   input  logic signed [SAMPLE_BITS-1:0] req_out_left,
   input  logic signed [SAMPLE_BITS-1:0] req_out_right,
   input  logic                          req_in_right_present,
   input  logic                          req_out_right_present,
   output logic [CHAN_BITS-1:0]          rsp_channel,
   output logic [SAMPLE_BITS-1:0]        rsp_rms_level,
   output logic [SAMPLE_BITS-1:0]        rsp_peak_level,
   output logic                          rsp_last
);

   localparam int SB     = SAMPLE_BITS;
   localparam int RUN_AW = (RUNS > 1) ? $clog2(RUNS) : 1;
   localparam int EXT_W  = RUN_AW + RUN_ID_BITS;
   localparam int DIV_CW = $clog2(SUM_BITS);
   localparam int SQ_CW  = $clog2(ROOT_BITS);

   // captured transaction
   logic                   mode_ff;
   logic [RUN_ID_BITS-1:0] run_ff;
   logic [SB-1:0]          samp_ff [CHANS];
   logic [CHANS-1:0]       pres_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff    <= req_mode;
         run_ff     <= req_run_id;
         samp_ff[0] <= req_in_left;
         samp_ff[1] <= req_in_right;
         samp_ff[2] <= req_out_left;
         samp_ff[3] <= req_out_right;
         pres_ff    <= {req_out_right_present, 1'b1, req_in_right_present, 1'b1};
      end
   end

   logic [EXT_W-1:0]  run_ext;
   logic              run_ok;
   logic [RUN_AW-1:0] run_addr;
   logic [RUN_AW-1:0] clr_ptr_ff;
   logic [RUN_AW-1:0] wr_addr;

   assign run_ext  = EXT_W'(run_ff);
   assign run_ok   = run_ext < EXT_W'(RUNS);
   assign run_addr = run_ext[RUN_AW-1:0];
   assign wr_addr  = cmd.clear ? clr_ptr_ff : run_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ptr_ff <= clr_ptr_ff + 1'b1;
      end
   end

   // per-channel lanes
   logic [SB-1:0]       abs_val [CHANS];
   logic [2*SB-1:0]     prod    [CHANS];
   logic [SB-1:0]       abs_ff  [CHANS];
   logic [SUM_BITS-1:0] sq_ff   [CHANS];
   logic [SUM_BITS-1:0] sum_rd  [CHANS];
   logic [SB-1:0]       peak_rd [CHANS];
   logic [SUM_BITS:0]   sum_add [CHANS];
   logic [SUM_BITS-1:0] sum_wd  [CHANS];
   logic [SB-1:0]       peak_wd [CHANS];
   logic [CHANS-1:0]    lane_we;

   always_comb begin
      for (int c = 0; c < CHANS; c++) begin
         abs_val[c] = samp_ff[c][SB-1] ? (~samp_ff[c] + 1'b1) : samp_ff[c];
         prod[c]    = abs_val[c] * abs_val[c];
         sum_add[c] = {1'b0, sum_rd[c]} + {1'b0, sq_ff[c]};
         if (cmd.clear) begin
            sum_wd[c]  = '0;
            peak_wd[c] = '0;
         end else begin
            sum_wd[c]  = sum_add[c][SUM_BITS] ? '1 : sum_add[c][SUM_BITS-1:0];
            peak_wd[c] = (abs_ff[c] > peak_rd[c]) ? abs_ff[c] : peak_rd[c];
         end
         lane_we[c] = cmd.clear | (cmd.write & run_ok & pres_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.square) begin
         for (int c = 0; c < CHANS; c++) begin
            abs_ff[c] <= abs_val[c];
            sq_ff[c]  <= SUM_BITS'(prod[c]);
         end
      end
   end

   for (genvar g = 0; g < CHANS; g++) begin : g_lane
      rpm_ram #(.WIDTH(SUM_BITS), .DEPTH(RUNS)) u_sum_ram (
         .clock (clock),
         .we    (lane_we[g]),
         .waddr (wr_addr),
         .wdata (sum_wd[g]),
         .raddr (run_addr),
         .rdata (sum_rd[g])
      );
      rpm_ram #(.WIDTH(SB), .DEPTH(RUNS)) u_peak_ram (
         .clock (clock),
         .we    (lane_we[g]),
         .waddr (wr_addr),
         .wdata (peak_wd[g]),
         .raddr (run_addr),
         .rdata (peak_rd[g])
      );
   end

   // sample count per run
   logic [COUNT_BITS-1:0] count_rd;
   logic [COUNT_BITS-1:0] count_wd;
   logic                  count_we;

   always_comb begin
      count_we = cmd.clear | (cmd.write & run_ok);
      if (cmd.clear) begin
         count_wd = '0;
      end else if (&count_rd) begin
         count_wd = count_rd;
      end else begin
         count_wd = count_rd + 1'b1;
      end
   end

   rpm_ram #(.WIDTH(COUNT_BITS), .DEPTH(RUNS)) u_count_ram (
      .clock (clock),
      .we    (count_we),
      .waddr (wr_addr),
      .wdata (count_wd),
      .raddr (run_addr),
      .rdata (count_rd)
   );

   // report channel
   logic [CHAN_BITS-1:0] chan_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         chan_ff <= '0;
      end else if (cmd.next_chan) begin
         chan_ff <= chan_ff + 1'b1;
      end
   end

   // restoring divider, one quotient bit per cycle
   logic [SUM_BITS-1:0]   dq_ff;
   logic [COUNT_BITS-1:0] drem_ff;
   logic [DIV_CW-1:0]     dcnt_ff;
   logic                  dbusy_ff;
   logic [COUNT_BITS:0]   drem_sh;
   logic                  dge;

   assign drem_sh = {drem_ff, dq_ff[SUM_BITS-1]};
   assign dge     = drem_sh >= {1'b0, count_rd};

   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
      end else if (cmd.div_start) begin
         dbusy_ff <= 1'b1;
      end else if (dbusy_ff && (dcnt_ff == DIV_CW'(SUM_BITS - 1))) begin
         dbusy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dq_ff   <= sum_rd[chan_ff];
         drem_ff <= '0;
         dcnt_ff <= '0;
      end else if (dbusy_ff) begin
         dq_ff   <= {dq_ff[SUM_BITS-2:0], dge};
         drem_ff <= dge ? COUNT_BITS'(drem_sh - {1'b0, count_rd})
                        : drem_sh[COUNT_BITS-1:0];
         dcnt_ff <= dcnt_ff + 1'b1;
      end
   end

   // digit-by-digit square root, one root bit per cycle
   logic [SUM_BITS-1:0]  sx_ff;
   logic [ROOT_BITS+1:0] srem_ff;
   logic [ROOT_BITS-1:0] root_ff;
   logic [SQ_CW-1:0]     scnt_ff;
   logic                 sbusy_ff;
   logic [ROOT_BITS+3:0] srem_sh;
   logic [ROOT_BITS+3:0] strial;
   logic                 sge;

   assign srem_sh = {srem_ff, sx_ff[SUM_BITS-1 -: 2]};
   assign strial  = {2'b00, root_ff, 2'b01};
   assign sge     = srem_sh >= strial;

   always_ff @(posedge clock) begin
      if (reset) begin
         sbusy_ff <= 1'b0;
      end else if (cmd.sqrt_start) begin
         sbusy_ff <= 1'b1;
      end else if (sbusy_ff && (scnt_ff == SQ_CW'(ROOT_BITS - 1))) begin
         sbusy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sqrt_start) begin
         sx_ff   <= dq_ff;
         srem_ff <= '0;
         root_ff <= '0;
         scnt_ff <= '0;
      end else if (sbusy_ff) begin
         sx_ff   <= {sx_ff[SUM_BITS-3:0], 2'b00};
         srem_ff <= sge ? (ROOT_BITS+2)'(srem_sh - strial)
                        : srem_sh[ROOT_BITS+1:0];
         root_ff <= {root_ff[ROOT_BITS-2:0], sge};
         scnt_ff <= scnt_ff + 1'b1;
      end
   end

   // result register
   localparam logic [ROOT_BITS:0] FULL_SCALE = (ROOT_BITS+1)'(1) << (SB - 1);

   logic [ROOT_BITS:0]   root_clamp;
   logic [CHAN_BITS-1:0] chan_out_ff;
   logic [SB-1:0]        rms_out_ff;
   logic [SB-1:0]        peak_out_ff;
   logic                 last_out_ff;

   assign root_clamp = ({1'b0, root_ff} > FULL_SCALE) ? FULL_SCALE : {1'b0, root_ff};

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         chan_out_ff <= chan_ff;
         rms_out_ff  <= (run_ok && (count_rd != '0)) ? root_clamp[SB-1:0] : '0;
         peak_out_ff <= run_ok ? peak_rd[chan_ff] : '0;
         last_out_ff <= (chan_ff == CHAN_LAST);
      end
   end

   assign rsp_channel    = chan_out_ff;
   assign rsp_rms_level  = rms_out_ff;
   assign rsp_peak_level = peak_out_ff;
   assign rsp_last       = last_out_ff;

   assign sts.clear_last = (clr_ptr_ff == RUN_AW'(RUNS - 1));
   assign sts.is_report  = (mode_ff == MODE_REPORT);
   assign sts.div_busy   = dbusy_ff;
   assign sts.sqrt_busy  = sbusy_ff;
   assign sts.chan_last  = (chan_ff == CHAN_LAST);

endmodule

// ===== sv/per_run_rms_peak_meter.sv =====
// per_run_rms_peak_meter: per-run RMS and peak meter for four audio channels.
// Sample transaction: read, then write back of the run entry before the next can be taken.
// Report transaction: four results, each through the divider and then the root.
// Throughput is set by the single read-modify-write port on each run store and the shared
// divider/root unit. After reset the stores are zeroed by a sweep over all RUNS rows
// with req_stall held high; control state is cleared synchronously by reset.
`timescale 1ns / 1ps

module per_run_rms_peak_meter
   import rpm_pkg::*;
#(
   parameter int RUNS        = 16,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_mode,
   input  logic [RUN_ID_BITS-1:0]        req_run_id,
   input  logic signed [SAMPLE_BITS-1:0] req_in_left,
   input  logic signed [SAMPLE_BITS-1:0] req_in_right,
   input  logic signed [SAMPLE_BITS-1:0] req_out_left,
   input  logic signed [SAMPLE_BITS-1:0] req_out_right,
   input  logic                          req_in_right_present,
   input  logic                          req_out_right_present,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [CHAN_BITS-1:0]          rsp_channel,
   output logic [SAMPLE_BITS-1:0]        rsp_rms_level,
   output logic [SAMPLE_BITS-1:0]        rsp_peak_level,
   output logic                          rsp_last
);

   // The controller sequences each transaction; the datapath owns the stores,
   // arithmetic and the result register. They talk only through cmd and sts.
   cmd_type cmd;
   sts_type sts;

   rpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Run stores are one row per run, a sum and a peak memory per channel plus a count memory;
   // the read address is always the captured run, so the row follows it into the registered read data.
   rpm_dp #(
      .RUNS        (RUNS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .req_mode              (req_mode),
      .req_run_id            (req_run_id),
      .req_in_left           (req_in_left),
      .req_in_right          (req_in_right),
      .req_out_left          (req_out_left),
      .req_out_right         (req_out_right),
      .req_in_right_present  (req_in_right_present),
      .req_out_right_present (req_out_right_present),
      .rsp_channel           (rsp_channel),
      .rsp_rms_level         (rsp_rms_level),
      .rsp_peak_level        (rsp_peak_level),
      .rsp_last              (rsp_last)
   );

endmodule

// ===== tb/sv/level_checker.sv =====
// level_checker: watches both channels of per_run_rms_peak_meter, predicts the report results
// and compares them. Depends on rpm_pkg for the mode and channel codes.
`timescale 1ns / 1ps

module level_checker
   import rpm_pkg::*;
#(
   parameter int RUNS        = 16,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          req_mode,
   input  logic [RUN_ID_BITS-1:0]        req_run_id,
   input  logic [SAMPLE_BITS-1:0]        req_in_left,
   input  logic [SAMPLE_BITS-1:0]        req_in_right,
   input  logic [SAMPLE_BITS-1:0]        req_out_left,
   input  logic [SAMPLE_BITS-1:0]        req_out_right,
   input  logic                          req_in_right_present,
   input  logic                          req_out_right_present,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [CHAN_BITS-1:0]          rsp_channel,
   input  logic [SAMPLE_BITS-1:0]        rsp_rms_level,
   input  logic [SAMPLE_BITS-1:0]        rsp_peak_level,
   input  logic                          rsp_last,
   output int                            fail_count,
   output int                            pending_levels
);

   localparam logic [63:0] FULL_SCALE = 64'd1 << (SAMPLE_BITS - 1);

   typedef struct packed {
      logic [CHAN_BITS-1:0]   channel;
      logic [SAMPLE_BITS-1:0] rms;
      logic [SAMPLE_BITS-1:0] peak;
      logic                   last;
   } level_type;

   logic [63:0]            energy [RUNS*CHANS];
   logic [SAMPLE_BITS-1:0] peak_hold [RUNS*CHANS];
   logic [31:0]            frames [RUNS];
   level_type              level_q [$];

   function automatic logic [63:0] root_floor(logic [63:0] x);
      logic [63:0] res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x   = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   task automatic add_energy(int slot, logic [SAMPLE_BITS-1:0] raw);
      logic [SAMPLE_BITS-1:0] neg;
      logic [63:0]            mag, sq;
      neg = ~raw + 1'b1;
      mag = raw[SAMPLE_BITS-1] ? 64'(neg) : 64'(raw);
      sq  = mag * mag;
      energy[slot] = (energy[slot] > ~sq) ? '1 : energy[slot] + sq;
      if (mag > 64'(peak_hold[slot])) peak_hold[slot] = mag[SAMPLE_BITS-1:0];
   endtask

   task automatic predict_levels(int run);
      level_type   lv;
      logic [63:0] r;
      for (int c = 0; c < CHANS; c++) begin
         lv.channel = c[CHAN_BITS-1:0];
         lv.last    = (c == CHANS - 1);
         lv.rms     = '0;
         lv.peak    = '0;
         if (run < RUNS) begin
            lv.peak = peak_hold[run*CHANS + c];
            if (frames[run] != 0) begin
               r = root_floor(energy[run*CHANS + c] / 64'(frames[run]));
               if (r > FULL_SCALE) r = FULL_SCALE;
               lv.rms = r[SAMPLE_BITS-1:0];
            end
         end
         level_q = {level_q, lv};
      end
   endtask

   always @(posedge clock) begin
      level_type exp_lv;
      int        run;
      if (reset) begin
         for (int i = 0; i < RUNS*CHANS; i++) begin
            energy[i]    = '0;
            peak_hold[i] = '0;
         end
         for (int i = 0; i < RUNS; i++) frames[i] = '0;
         level_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (level_q.size() == 0) begin
               $display("%0t: unexpected result ch=%0d rms=%0d peak=%0d last=%0b", $time,
                        rsp_channel, rsp_rms_level, rsp_peak_level, rsp_last);
               fail_count++;
            end else begin
               exp_lv = level_q.pop_front();
               if (exp_lv.channel !== rsp_channel || exp_lv.rms !== rsp_rms_level ||
                   exp_lv.peak !== rsp_peak_level || exp_lv.last !== rsp_last) begin
                  $display("%0t: mismatch expected ch=%0d rms=%0d peak=%0d last=%0b",
                           $time, exp_lv.channel, exp_lv.rms, exp_lv.peak, exp_lv.last);
                  $display("%0t:          actual   ch=%0d rms=%0d peak=%0d last=%0b",
                           $time, rsp_channel, rsp_rms_level, rsp_peak_level, rsp_last);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            run = req_run_id;
            if (req_mode == MODE_REPORT) begin
               predict_levels(run);
            end else if (run < RUNS) begin
               add_energy(run*CHANS + 0, req_in_left);
               if (req_in_right_present) add_energy(run*CHANS + 1, req_in_right);
               add_energy(run*CHANS + 2, req_out_left);
               if (req_out_right_present) add_energy(run*CHANS + 3, req_out_right);
               if (frames[run] != '1) frames[run]++;
            end
         end
      end
      pending_levels = level_q.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
// tb: stimulus and verdict for per_run_rms_peak_meter; level_checker does the prediction.
// Depends on rpm_pkg, per_run_rms_peak_meter and level_checker.
`timescale 1ns / 1ps

module tb
   import rpm_pkg::*;
;

   localparam int RUNS        = 16;
   localparam int SAMPLE_BITS = 24;
   localparam int STALL_LIMIT = 20000;

   logic                   clock, reset;
   logic                   req_valid, req_stall, req_mode;
   logic [RUN_ID_BITS-1:0] req_run_id;
   logic [SAMPLE_BITS-1:0] req_in_left, req_in_right, req_out_left, req_out_right;
   logic                   req_in_right_present, req_out_right_present;
   logic                   rsp_valid, rsp_stall, rsp_last;
   logic [CHAN_BITS-1:0]   rsp_channel;
   logic [SAMPLE_BITS-1:0] rsp_rms_level, rsp_peak_level;
   int                     fail_count, pending_levels;
   int                     send_idle_pct, recv_idle_pct;
   int                     quiet_cycles;
   bit                     timed_out;

   per_run_rms_peak_meter #(.RUNS(RUNS), .SAMPLE_BITS(SAMPLE_BITS)) u_top (.*);
   level_checker #(.RUNS(RUNS), .SAMPLE_BITS(SAMPLE_BITS)) u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: stall at random according to the current phase.
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Watchdog: count cycles in which neither channel moves a transaction.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("** per_run_rms_peak_meter: FAILED **");
            $finish;
         end
      end
   end

   // Offer one transaction, with a random gap first; hold it until accepted.
   // Valid stays high after acceptance unless a gap follows.
   task automatic send(logic mode, logic [RUN_ID_BITS-1:0] run,
                       logic [SAMPLE_BITS-1:0] il, ir, ol, orr, logic irp, orp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_mode              <= mode;
      req_run_id            <= run;
      req_in_left           <= il;
      req_in_right          <= ir;
      req_out_left          <= ol;
      req_out_right         <= orr;
      req_in_right_present  <= irp;
      req_out_right_present <= orp;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   function automatic logic [SAMPLE_BITS-1:0] rand_sample();
      case ($urandom_range(5))
         0: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         1: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         2: return SAMPLE_BITS'($urandom_range(15)) - SAMPLE_BITS'(8);
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   task automatic random_sample(logic [RUN_ID_BITS-1:0] run);
      send(MODE_SAMPLE, run, rand_sample(), rand_sample(), rand_sample(), rand_sample(),
           1'($urandom), 1'($urandom));
   endtask

   task automatic report(logic [RUN_ID_BITS-1:0] run);
      send(MODE_REPORT, run, SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom),
           SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom), 1'($urandom), 1'($urandom));
   endtask

   // Random phase: mostly short sample bursts on one run closed by its report.
   task automatic random_phase(int items);
      int sent, burst;
      logic [RUN_ID_BITS-1:0] run;
      sent = 0;
      while (sent < items) begin
         run   = RUN_ID_BITS'($urandom_range(RUNS - 1));
         burst = $urandom_range(6);
         for (int i = 0; i < burst; i++) random_sample(run);
         if ($urandom_range(9) == 0) begin
            random_sample(RUN_ID_BITS'($urandom));
            sent++;
         end
         report(run);
         sent += burst + 1;
      end
   endtask

   localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

   initial begin
      timed_out             = 1'b0;
      send_idle_pct         = 0;
      recv_idle_pct         = 0;
      reset                 <= 1'b1;
      req_valid             <= 1'b0;
      req_mode              <= MODE_SAMPLE;
      req_run_id            <= '0;
      req_in_left           <= '0;
      req_in_right          <= '0;
      req_out_left          <= '0;
      req_out_right         <= '0;
      req_in_right_present  <= 1'b0;
      req_out_right_present <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty run, extremes, absent right channels, most negative sample.
      report(4'd0);
      send(MODE_SAMPLE, 4'd1, S_MIN, S_MIN, S_MIN, S_MIN, 1'b1, 1'b1);
      send(MODE_SAMPLE, 4'd1, S_MAX, S_MAX, S_MAX, S_MAX, 1'b1, 1'b1);
      report(4'd1);
      send(MODE_SAMPLE, 4'd2, S_MAX, S_MIN, 24'h000001, S_MIN, 1'b0, 1'b0);
      send(MODE_SAMPLE, 4'd2, 24'hFFFFFF, 24'h123456, 24'h000000, S_MAX, 1'b1, 1'b0);
      report(4'd2);
      send(MODE_SAMPLE, 4'd15, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 1'b0, 1'b1);
      report(4'd15);
      report(4'd3);
      for (int i = 0; i < 4; i++) send(MODE_SAMPLE, 4'd4, S_MIN, S_MAX, 24'hAAAAAA,
                                       24'h555555, 1'b1, 1'b1);
      report(4'd4);
      report(4'd1);

      send_idle_pct = 35; recv_idle_pct = 63;
      random_phase(130);
      send_idle_pct = 63; recv_idle_pct = 35;
      random_phase(130);
      send_idle_pct = 0;  recv_idle_pct = 0;
      random_phase(125);
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_levels != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending_levels == 0)
         $display("** per_run_rms_peak_meter: PASSED **");
      else
         $display("** per_run_rms_peak_meter: FAILED **");
      $finish;
   end

endmodule

// ===== files.f =====
sv/rpm_pkg.sv
sv/rpm_ram.sv
sv/rpm_ctrl.sv
sv/rpm_dp.sv
sv/per_run_rms_peak_meter.sv
tb/sv/level_checker.sv
tb/sv/tb.sv
